// ===== sv/shabs_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
// Used by shabs_core and sha256_byte_stream_hasher; depends on nothing else.
package shabs_pkg;

    typedef logic [31:0] word_t;
    typedef word_t hash_t [8];

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd7;

    localparam hash_t INIT_H = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Control from the byte sequencer to the compression unit.
    typedef struct packed {
        logic       load;
        logic [7:0] load_byte;
        logic       start;
        logic       reinit;
    } core_ctl_t;

    function automatic word_t big_sig0(input word_t x);
        big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sig1(input word_t x);
        big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sig0(input word_t x);
        small_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sig1(input word_t x);
        small_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== sv/shabs_core.sv =====
// SHA-256 compression unit: a 512-bit word window, eight working variables
// and one round datapath reused for all 64 rounds. Depends on shabs_pkg.
module shabs_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  shabs_pkg::core_ctl_t ctl,
    output logic                 done,
    output shabs_pkg::hash_t     chain_hash
);

    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_ROUND = 3'b010,
        C_FINAL = 3'b100
    } core_state_t;

    core_state_t      state_reg, state_next;
    logic [5:0]       rnd_reg, rnd_next;
    logic [511:0]     win_reg, win_next;
    shabs_pkg::hash_t v_reg, v_next;
    shabs_pkg::hash_t h_reg, h_next;

    shabs_pkg::word_t w0, w1, w9, w14, new_w, t1, t2, ch, maj;

    // The window holds W[t] .. W[t+15], W[t] in the top word.
    assign w0  = win_reg[511:480];
    assign w1  = win_reg[479:448];
    assign w9  = win_reg[223:192];
    assign w14 = win_reg[63:32];

    always_comb
    begin
        new_w = shabs_pkg::small_sig1(w14) + w9 + shabs_pkg::small_sig0(w1) + w0;
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1    = v_reg[7] + shabs_pkg::big_sig1(v_reg[4]) + ch
                + shabs_pkg::ROUND_K[rnd_reg] + w0;
        t2    = shabs_pkg::big_sig0(v_reg[0]) + maj;
    end

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        win_next   = win_reg;
        v_next     = v_reg;
        h_next     = h_reg;
        done       = 1'b0;
        unique case (state_reg)
            C_IDLE:
            begin
                if (ctl.load)
                begin
                    win_next = {win_reg[503:0], ctl.load_byte};
                end
                if (ctl.start)
                begin
                    v_next     = h_reg;
                    rnd_next   = '0;
                    state_next = C_ROUND;
                end
                if (ctl.reinit)
                begin
                    h_next = shabs_pkg::INIT_H;
                end
            end
            C_ROUND:
            begin
                win_next  = {win_reg[479:0], new_w};
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == shabs_pkg::ROUND_LAST)
                begin
                    state_next = C_FINAL;
                end
            end
            C_FINAL:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_next[i] = h_reg[i] + v_reg[i];
                end
                done       = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            h_reg     <= shabs_pkg::INIT_H;
        end
        else
        begin
            state_reg <= state_next;
            h_reg     <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg <= rnd_next;
        win_reg <= win_next;
        v_reg   <= v_next;
    end

    assign chain_hash = h_reg;

endmodule

// ===== sv/sha256_byte_stream_hasher.sv =====
// SHA-256 byte stream hasher top level: byte sequencer, padding, digest output.
// Depends on shabs_pkg and shabs_core.
//
// Usage: the input channel (in_valid/in_stall) takes one request per cycle
// while the block is idle, carrying an optional message byte and an end flag.
// The output channel (out_valid/out_stall) delivers the eight digest words,
// word 0 first, each with its word_index, and last_word set on the final one.
// A byte that does not complete a 64-byte block and has no end flag leaves
// in_stall low. A byte that completes a block holds in_stall high while the
// 64 rounds run on the single round datapath and the result is folded
// into the chaining hash. At the end of a message the padding is shifted in
// one byte per cycle (64 - fill bytes, or 128 - fill for a tail of 56 or
// more), each padded block is compressed the same way, and then the eight
// digest words follow, one per cycle when the receiver does not stall.
// While out_stall is high the current word holds and no input is taken.
// Reset loads the initial hash values and clears the fill and length
// counters; in_stall is low out of reset, so a request can be taken once
// reset is released.
module sha256_byte_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_RUN    = 5'b00010,
        ST_PAD    = 5'b00100,
        ST_PADRUN = 5'b01000,
        ST_OUT    = 5'b10000
    } top_state_t;

    top_state_t           state_reg, state_next;
    logic [5:0]           fill_reg, fill_next;
    logic [63:0]          count_reg, count_next;
    logic                 eom_pend_reg, eom_pend_next;
    logic                 first_reg, first_next;
    logic                 len_ok_reg, len_ok_next;
    logic [2:0]           idx_reg, idx_next;

    shabs_pkg::core_ctl_t ctl;
    logic                 core_done;
    shabs_pkg::hash_t     chain_hash;

    logic                 in_take;
    logic                 out_take;
    logic [63:0]          len_bits;
    logic [7:0]           len_byte;
    logic [7:0]           pad_byte;

    shabs_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .done       (core_done),
        .chain_hash (chain_hash)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid && !out_stall;

    // Length bytes go out most significant first at fill 56 through 63.
    assign len_bits = {count_reg[60:0], 3'b000};
    assign len_byte = len_bits[{~fill_reg[2:0], 3'b000} +: 8];

    always_comb
    begin
        priority if (first_reg)
        begin
            pad_byte = shabs_pkg::PAD_BYTE;
        end
        else if (len_ok_reg && (fill_reg >= shabs_pkg::LEN_POS))
        begin
            pad_byte = len_byte;
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    always_comb
    begin
        ctl.load      = (in_take && byte_present) || (state_reg == ST_PAD);
        ctl.load_byte = (state_reg == ST_PAD) ? pad_byte : data_byte;
        ctl.start     = ctl.load && (fill_reg == shabs_pkg::BLOCK_LAST);
        ctl.reinit    = out_take && (idx_reg == shabs_pkg::WORD_LAST);
    end

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = ctl.load ? fill_reg + 6'd1 : fill_reg;
        count_next    = count_reg;
        eom_pend_next = eom_pend_reg;
        first_next    = first_reg;
        len_ok_next   = len_ok_reg;
        idx_next      = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (byte_present)
                    begin
                        count_next = count_reg + 64'd1;
                    end
                    if (byte_present && (fill_reg == shabs_pkg::BLOCK_LAST))
                    begin
                        eom_pend_next = end_of_message;
                        state_next    = ST_RUN;
                    end
                    else if (end_of_message)
                    begin
                        first_next = 1'b1;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_RUN:
            begin
                if (core_done)
                begin
                    if (eom_pend_reg)
                    begin
                        first_next = 1'b1;
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PAD:
            begin
                first_next = 1'b0;
                if (first_reg)
                begin
                    // The length fits in this block only if the pad byte lands
                    // before the length field.
                    len_ok_next = (fill_reg < shabs_pkg::LEN_POS);
                end
                if (fill_reg == shabs_pkg::BLOCK_LAST)
                begin
                    state_next = ST_PADRUN;
                end
            end
            ST_PADRUN:
            begin
                if (core_done)
                begin
                    if (len_ok_reg)
                    begin
                        idx_next   = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        len_ok_next = 1'b1;
                        state_next  = ST_PAD;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_take)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == shabs_pkg::WORD_LAST)
                    begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            count_reg    <= '0;
            eom_pend_reg <= 1'b0;
            first_reg    <= 1'b0;
            len_ok_reg   <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            count_reg    <= count_next;
            eom_pend_reg <= eom_pend_next;
            first_reg    <= first_next;
            len_ok_reg   <= len_ok_next;
            idx_reg      <= idx_next;
        end
    end

    assign digest_word = chain_hash[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == shabs_pkg::WORD_LAST);

    // The compression unit only finishes while the sequencer waits for it.
    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        core_done |-> (state_reg == ST_RUN || state_reg == ST_PADRUN))
        else $error("compression finished outside a run state");

    // Every digest is produced from a completely consumed block.
    a_fill_at_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fill_reg == 6'd0))
        else $error("digest shown with a partly filled block");

    // After the last word is taken, the block is ready for a fresh message.
    a_ready_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && last_word) |=> (!in_stall && count_reg == 64'd0 && !out_valid))
        else $error("block not reinitialized after the digest");

    // A new request is never taken while padding is pending.
    a_no_take_in_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD) |-> (in_stall && !out_valid))
        else $error("channel open during padding");

endmodule

// ===== verif/sha256_byte_stream_hasher_test.sv =====
// Self-checking testbench for sha256_byte_stream_hasher: byte messages in, digest words out.
// Holds its own SHA-256 model of the hasher and checks every digest word in order.
// Depends only on the sha256_byte_stream_hasher RTL.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_test;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 400;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_TARGET = 185;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam int LEN_OFFSET = 56;

    localparam logic [0:63][31:0] ROUND_CONST = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [0:7][31:0] START_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct {
        logic [7:0] data;
        logic       present;
        logic       eom;
    } hash_req_t;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_entry_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        byte_present = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    hash_req_t     pending_reqs [$];
    digest_entry_t digest_due [$];
    hash_req_t     next_req;

    // Model state: chaining hash, partial block, fill level and byte count.
    logic [31:0]  chain_h [8];
    logic [511:0] msg_block;
    int           block_fill;
    logic [63:0]  msg_bytes;

    logic req_taken = 1'b0;
    int   reqs_taken = 0;
    int   total_reqs = 0;
    int   random_items = 0;
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   send_idle_pct = 14;
    int   recv_idle_pct = 53;

    sha256_byte_stream_hasher dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .byte_present(byte_present),
        .end_of_message(end_of_message),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .digest_word(digest_word),
        .word_index(word_index),
        .last_word(last_word)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void compress_block(input logic [511:0] blk);
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        int i;
        for (i = 0; i < 16; i++)
            w[i] = blk[511 - 32 * i -: 32];
        for (i = 16; i < 64; i++)
        begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (i = 0; i < 64; i++)
        begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_CONST[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++)
            chain_h[i] = START_HASH[i];
        block_fill = 0;
        msg_bytes = '0;
    endfunction

    // Applies one accepted request to the model and queues any digest it completes.
    function automatic void hash_request(input logic [7:0] value, input logic present,
                                         input logic eom);
        logic [1023:0] tail;
        logic [63:0]   bit_len;
        digest_entry_t entry;
        int i;
        if (present)
        begin
            msg_block[511 - 8 * block_fill -: 8] = value;
            block_fill++;
            msg_bytes++;
            if (block_fill == 64)
            begin
                compress_block(msg_block);
                block_fill = 0;
            end
        end
        if (!eom)
            return;
        tail = '0;
        for (i = 0; i < block_fill; i++)
            tail[1023 - 8 * i -: 8] = msg_block[511 - 8 * i -: 8];
        tail[1023 - 8 * block_fill -: 8] = PAD_MARK;
        bit_len = msg_bytes << 3;
        if (block_fill < LEN_OFFSET)
        begin
            tail[1023 - 8 * LEN_OFFSET -: 64] = bit_len;
            compress_block(tail[1023:512]);
        end
        else
        begin
            tail[63:0] = bit_len;
            compress_block(tail[1023:512]);
            compress_block(tail[511:0]);
        end
        for (i = 0; i < 8; i++)
        begin
            entry.word = chain_h[i];
            entry.index = i[2:0];
            entry.last = (i == 7);
            digest_due.push_back(entry);
        end
        restart_message();
    endfunction

    function automatic void check_digest_word();
        digest_entry_t want;
        if (digest_due.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected digest word %h index %0d last %0b",
                         digest_word, word_index, last_word);
            return;
        end
        want = digest_due.pop_front();
        if (digest_word !== want.word || word_index !== want.index || last_word !== want.last)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                         want.word, want.index, want.last,
                         digest_word, word_index, last_word);
        end
    endfunction

    function automatic void push_req(input logic [7:0] value, input logic present,
                                     input logic eom);
        hash_req_t req;
        req.data = value;
        req.present = present;
        req.eom = eom;
        pending_reqs.push_back(req);
        total_reqs++;
    endfunction

    // Queues one message of random bytes with a few ignored requests mixed in.
    // The end flag rides on the last byte or comes as a request of its own.
    function automatic void queue_message(input int nbytes);
        logic end_on_byte;
        int i;
        end_on_byte = (nbytes > 0) && ($urandom_range(1) == 1);
        for (i = 0; i < nbytes; i++)
        begin
            if ($urandom_range(99) < 8)
                push_req(8'($urandom_range(255)), 1'b0, 1'b0);
            push_req(8'($urandom_range(255)), 1'b1, end_on_byte && (i == nbytes - 1));
            random_items++;
        end
        if (!end_on_byte)
        begin
            push_req(8'($urandom_range(255)), 1'b0, 1'b1);
            random_items++;
        end
    endfunction

    // Driver: a new request goes out only once the previous one was accepted.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (rst_n && (!in_valid || req_taken))
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_req = pending_reqs.pop_front();
                in_valid <= 1'b1;
                data_byte <= next_req.data;
                byte_present <= next_req.present;
                end_of_message <= next_req.eom;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: feeds accepted requests to the model and checks accepted words.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[sha256_byte_stream_hasher] ERROR");
            $finish;
        end
        req_taken <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                hash_request(data_byte, byte_present, end_of_message);
                reqs_taken <= reqs_taken + 1;
            end
            if (out_valid && !out_stall)
                check_digest_word();
        end
    end

    initial
    begin
        int len, pick;
        restart_message();
        msg_block = '0;

        // Empty message, an ignored request, then a single zero byte with the end.
        push_req(8'h5a, 1'b0, 1'b1);
        push_req(8'ha5, 1'b0, 1'b0);
        push_req(8'h00, 1'b1, 1'b1);
        // All-ones byte, then an end request with no byte.
        push_req(8'hff, 1'b1, 1'b0);
        push_req(8'hff, 1'b0, 1'b1);
        // The classic three-byte test vector.
        push_req(8'h61, 1'b1, 1'b0);
        push_req(8'h62, 1'b1, 1'b0);
        push_req(8'h63, 1'b1, 1'b1);

        // A tail long enough to need two padding blocks, then a mix of lengths.
        queue_message($urandom_range(63, 56));
        while (random_items < RANDOM_TARGET)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                len = $urandom_range(12);
            else if (pick < 70)
                len = $urandom_range(66, 50);
            else
                len = $urandom_range(140, 64);
            // The last message is cut short so the run stays near its planned size.
            if (len > RANDOM_TARGET - random_items)
                len = RANDOM_TARGET - random_items;
            queue_message(len);
        end

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        while (reqs_taken < total_reqs / 3)
            @(posedge clk);
        send_idle_pct = 53;
        recv_idle_pct = 14;
        while (reqs_taken < (2 * total_reqs) / 3)
            @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (reqs_taken < total_reqs || digest_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("[sha256_byte_stream_hasher] OK");
        else
            $display("[sha256_byte_stream_hasher] ERROR");
        $finish;
    end

endmodule
